### sv/rsa_pkg.sv
`timescale 1ns / 1ps

package rsa_pkg;

  // Field widths
  localparam int WORD_W    = 32;
  localparam int OPERAND_W = 31;
  localparam int REQ_W     = 2;
  localparam int OP_W      = 2;
  localparam int STS_W     = 3;
  localparam int MODE_W    = 2;
  localparam int ADDR_W    = 3;
  localparam int PDATA_W   = 32;

  localparam int STACK_DEPTH_DEF = 16;

  // Request types (code 3 behaves as finish)
  localparam logic [REQ_W-1:0] REQ_PUSH   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_OPER   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FINISH = 2'd2;

  // Operator codes
  localparam logic [OP_W-1:0] OP_ADD = 2'd0;
  localparam logic [OP_W-1:0] OP_SUB = 2'd1;
  localparam logic [OP_W-1:0] OP_MUL = 2'd2;
  localparam logic [OP_W-1:0] OP_BAD = 2'd3;

  // Result status codes
  localparam logic [STS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STS_W-1:0] ST_UNDER = 3'd1;
  localparam logic [STS_W-1:0] ST_OVF   = 3'd2;
  localparam logic [STS_W-1:0] ST_BADOP = 3'd3;
  localparam logic [STS_W-1:0] ST_FULL  = 3'd4;

  // Word width modes (code 3 behaves as 32 bits)
  localparam logic [MODE_W-1:0] MODE_8  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_16 = 2'd1;
  localparam logic [MODE_W-1:0] MODE_32 = 2'd2;

  // Register addresses
  localparam logic [ADDR_W-1:0] ADDR_WIDTH_MODE = 3'd0;

  // Stack update request from the ALU
  typedef struct packed {
    logic              push;
    logic              merge;   // pop two, push result
    logic              clear;
    logic [WORD_W-1:0] data;
  } stk_cmd_t;

  // Stack occupancy flags
  typedef struct packed {
    logic full;
    logic has1;
    logic has2;
  } stk_sts_t;

  // Sign-extend the low word of v per width mode
  function automatic logic [WORD_W-1:0] sext_word(input logic [WORD_W-1:0] v,
                                                  input logic [MODE_W-1:0] mode);
    logic [WORD_W-1:0] r;
    case (mode)
      MODE_8:  r = {{24{v[7]}}, v[7:0]};
      MODE_16: r = {{16{v[15]}}, v[15:0]};
      default: r = v;
    endcase
    return r;
  endfunction

  // True when a 64-bit signed value fits the signed word range
  function automatic logic fits_word(input logic [63:0] r,
                                     input logic [MODE_W-1:0] mode);
    logic ok;
    case (mode)
      MODE_8:  ok = (&r[63:7])  | ~(|r[63:7]);
      MODE_16: ok = (&r[63:15]) | ~(|r[63:15]);
      default: ok = (&r[63:31]) | ~(|r[63:31]);
    endcase
    return ok;
  endfunction

endpackage

### sv/rpn_stack_alu.sv
`timescale 1ns / 1ps

// Channel   Ports                                          Direction
// -------   ---------------------------------------------  ---------
// input     in_valid, in_stall, in_req_type, in_operand,   in
//           in_op_code
// result    out_valid, out_stall, out_status, out_value,   out
//           out_done_res
// config    psel, penable, pwrite, paddr, pwdata,          in/out
//           prdata, pready
//
// One item per cycle while the result register is not stalled; each item's
// result moves from the input register to the result register in one
// stack/ALU pass, which updates the stack and uses one 32x32 multiplier.
// Synchronous active-low reset empties the stack and sets 32-bit words.
// A stalled result register holds the item in the input register, and
// in_stall rises only while both registers are full.
module rpn_stack_alu #(
  parameter int STACK_DEPTH = rsa_pkg::STACK_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [rsa_pkg::REQ_W-1:0]         in_req_type,
  input  logic [rsa_pkg::OPERAND_W-1:0]     in_operand,
  input  logic [rsa_pkg::OP_W-1:0]          in_op_code,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [rsa_pkg::STS_W-1:0]         out_status,
  output logic signed [rsa_pkg::WORD_W-1:0] out_value,
  output logic                              out_done_res,
  // config port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rsa_pkg::ADDR_W-1:0]        paddr,
  input  logic [rsa_pkg::PDATA_W-1:0]       pwdata,
  output logic [rsa_pkg::PDATA_W-1:0]       prdata,
  output logic                              pready
);

  // Config register
  logic [rsa_pkg::MODE_W-1:0] width_mode_r;

  assign pready = 1'b1;
  assign prdata = (paddr == rsa_pkg::ADDR_WIDTH_MODE) ?
                  {{(rsa_pkg::PDATA_W-rsa_pkg::MODE_W){1'b0}}, width_mode_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_mode_r <= rsa_pkg::MODE_32;
    end else if (psel && penable && pwrite && pready &&
                 paddr == rsa_pkg::ADDR_WIDTH_MODE) begin
      width_mode_r <= pwdata[rsa_pkg::MODE_W-1:0];
    end
  end

  // Pipeline control
  logic s1_v_r;
  logic out_v_r;
  logic out_adv;
  logic s1_fire;
  logic in_take;

  assign out_adv  = !out_v_r || !out_stall;
  assign s1_fire  = s1_v_r && out_adv;
  assign in_stall = s1_v_r && !out_adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_v_r <= in_valid;
      end
      if (out_adv) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  // Input register
  logic [rsa_pkg::REQ_W-1:0]     s1_req_r;
  logic [rsa_pkg::OPERAND_W-1:0] s1_operand_r;
  logic [rsa_pkg::OP_W-1:0]      s1_op_r;

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_req_r     <= in_req_type;
      s1_operand_r <= in_operand;
      s1_op_r      <= in_op_code;
    end
  end

  // Stack and ALU
  rsa_pkg::stk_cmd_t          cmd;
  rsa_pkg::stk_sts_t          sts;
  logic [rsa_pkg::WORD_W-1:0] tos;
  logic [rsa_pkg::WORD_W-1:0] nos;
  logic [rsa_pkg::STS_W-1:0]  res_status;
  logic [rsa_pkg::WORD_W-1:0] res_value;
  logic                       res_done;

  rsa_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd_en (s1_fire),
    .cmd    (cmd),
    .tos    (tos),
    .nos    (nos),
    .sts    (sts)
  );

  rsa_alu u_alu (
    .req_type   (s1_req_r),
    .operand    (s1_operand_r),
    .op_code    (s1_op_r),
    .width_mode (width_mode_r),
    .tos        (tos),
    .nos        (nos),
    .sts        (sts),
    .cmd        (cmd),
    .status     (res_status),
    .value      (res_value),
    .done_res   (res_done)
  );

  // Result register
  logic [rsa_pkg::STS_W-1:0]  out_status_r;
  logic [rsa_pkg::WORD_W-1:0] out_value_r;
  logic                       out_done_r;

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_status_r <= res_status;
      out_value_r  <= res_value;
      out_done_r   <= res_done;
    end
  end

  assign out_valid    = out_v_r;
  assign out_status   = out_status_r;
  assign out_value    = out_value_r;
  assign out_done_res = out_done_r;

`ifndef NO_ASSERTIONS
  // Error results end the expression and carry a zero value
  a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != rsa_pkg::ST_OK |-> out_done_res && out_value == '0)
    else $error("error result without done or with nonzero value");

  // Input stalls only while an item sits in the input register
  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_v_r)
    else $error("in_stall with empty input register");

  // An item that ends the expression leaves an empty stack
  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && res_done |=> !sts.has1)
    else $error("stack not empty after done item");

  // A full stack always holds at least two entries
  a_full_two: assert property (@(posedge clk) disable iff (!rst_n)
    sts.full |-> sts.has2 && sts.has1)
    else $error("occupancy flags inconsistent");
`endif

endmodule

### sv/rsa_stack.sv
`timescale 1ns / 1ps

// Operand stack as a row of shifting entries; entry 0 is top of stack.
module rsa_stack #(
  parameter int STACK_DEPTH = rsa_pkg::STACK_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        upd_en,
  input  rsa_pkg::stk_cmd_t           cmd,
  output logic [rsa_pkg::WORD_W-1:0]  tos,
  output logic [rsa_pkg::WORD_W-1:0]  nos,
  output rsa_pkg::stk_sts_t           sts
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  logic [rsa_pkg::WORD_W-1:0] stk_r [STACK_DEPTH];
  logic [CNT_W-1:0]           cnt_r;
  logic [CNT_W-1:0]           cnt_nxt;

  // Entry count
  always_comb begin
    cnt_nxt = cnt_r;
    if (upd_en) begin
      if (cmd.clear) begin
        cnt_nxt = '0;
      end else if (cmd.push) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end else if (cmd.merge) begin
        cnt_nxt = cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Entries: push shifts down, merge shifts up under the new top
  always_ff @(posedge clk) begin
    if (upd_en && !cmd.clear && (cmd.push || cmd.merge)) begin
      stk_r[0] <= cmd.data;
      if (cmd.push) begin
        for (int i = 1; i < STACK_DEPTH; i++) begin
          stk_r[i] <= stk_r[i-1];
        end
      end else begin
        for (int i = 1; i < STACK_DEPTH - 1; i++) begin
          stk_r[i] <= stk_r[i+1];
        end
      end
    end
  end

  assign tos      = stk_r[0];
  assign nos      = stk_r[1];
  assign sts.full = (cnt_r == CNT_W'(STACK_DEPTH));
  assign sts.has1 = (cnt_r != '0);
  assign sts.has2 = (cnt_r >= CNT_W'(2));

endmodule

### sv/rsa_alu.sv
`timescale 1ns / 1ps

// Executes one item against the two top entries; pure logic.
module rsa_alu (
  input  logic [rsa_pkg::REQ_W-1:0]     req_type,
  input  logic [rsa_pkg::OPERAND_W-1:0] operand,
  input  logic [rsa_pkg::OP_W-1:0]      op_code,
  input  logic [rsa_pkg::MODE_W-1:0]    width_mode,
  input  logic [rsa_pkg::WORD_W-1:0]    tos,
  input  logic [rsa_pkg::WORD_W-1:0]    nos,
  input  rsa_pkg::stk_sts_t             sts,
  output rsa_pkg::stk_cmd_t             cmd,
  output logic [rsa_pkg::STS_W-1:0]     status,
  output logic [rsa_pkg::WORD_W-1:0]    value,
  output logic                          done_res
);

  logic [rsa_pkg::WORD_W-1:0] push_v;
  logic signed [rsa_pkg::WORD_W-1:0] a;
  logic signed [rsa_pkg::WORD_W-1:0] b;
  logic signed [63:0] a64;
  logic signed [63:0] b64;
  logic signed [63:0] prod64;
  logic [63:0]        r64;

  assign push_v = rsa_pkg::sext_word({1'b0, operand}, width_mode);
  assign a      = rsa_pkg::sext_word(nos, width_mode);
  assign b      = rsa_pkg::sext_word(tos, width_mode);
  assign a64    = {{32{a[31]}}, a};
  assign b64    = {{32{b[31]}}, b};
  assign prod64 = a * b;

  // Arithmetic result, full precision
  always_comb begin
    case (op_code)
      rsa_pkg::OP_ADD: r64 = a64 + b64;
      rsa_pkg::OP_SUB: r64 = a64 - b64;
      default:         r64 = prod64;
    endcase
  end

  // Item decode and error priority
  always_comb begin
    cmd      = '0;
    status   = rsa_pkg::ST_OK;
    value    = '0;
    done_res = 1'b0;
    unique case (req_type)
      rsa_pkg::REQ_PUSH: begin
        if (sts.full) begin
          status    = rsa_pkg::ST_FULL;
          done_res  = 1'b1;
          cmd.clear = 1'b1;
        end else begin
          cmd.push = 1'b1;
          cmd.data = push_v;
          value    = push_v;
        end
      end
      rsa_pkg::REQ_OPER: begin
        if (!sts.has2) begin
          status    = rsa_pkg::ST_UNDER;
          done_res  = 1'b1;
          cmd.clear = 1'b1;
        end else if (op_code == rsa_pkg::OP_BAD) begin
          status    = rsa_pkg::ST_BADOP;
          done_res  = 1'b1;
          cmd.clear = 1'b1;
        end else if (!rsa_pkg::fits_word(r64, width_mode)) begin
          status    = rsa_pkg::ST_OVF;
          done_res  = 1'b1;
          cmd.clear = 1'b1;
        end else begin
          cmd.merge = 1'b1;
          cmd.data  = r64[31:0];
          value     = r64[31:0];
        end
      end
      default: begin
        // finish
        done_res  = 1'b1;
        cmd.clear = 1'b1;
        if (!sts.has1) begin
          status = rsa_pkg::ST_UNDER;
        end else begin
          value = b;
        end
      end
    endcase
  end

endmodule
